>>> design/gclock_page_replacement_core_macros.svh
// assertion macros for the gclock page replacement core
// used by the checker module; no other dependencies
`ifndef GCLOCK_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define GCLOCK_PAGE_REPLACEMENT_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gclock assertion failed");

// next-cycle implication, disabled during reset
`define GC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gclock assertion failed");

`endif

>>> design/gclock_pkg.sv
// package for the gclock page replacement core: widths, defaults, fsm type
// no dependencies
package gclock_pkg;

   localparam int SLOTS_DEF = 64;
   localparam int KEY_W     = 64;
   localparam int REF_W     = 8;
   localparam int IDX_W     = 6;

   localparam logic [REF_W-1:0] CAP_RESET = 8'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP_RD,
      ST_SWEEP_CHK,
      ST_DONE
   } state_type;

endpackage

>>> design/gclock_if.sv
// valid/ready channel interfaces for request and response beats
// depends on gclock_pkg for field widths
interface gclock_req_if import gclock_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] page_key;

   modport source (output valid, output page_key, input ready);
   modport sink (input valid, input page_key, output ready);
endinterface

interface gclock_rsp_if import gclock_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             hit;
   logic [IDX_W-1:0] slot_index;

   modport source (output valid, output hit, output slot_index, input ready);
   modport sink (input valid, input hit, input slot_index, output ready);
endinterface

>>> design/gclock_page_replacement_core.sv
// gclock page replacement core: key and count memories, lookup scan, clock sweep
// depends on gclock_pkg and the gclock_req_if / gclock_rsp_if interfaces
// one item at a time; lookup reads one slot per cycle from the key memory port.
// eviction: after a miss on a full array, the hand sweeps the slots, decrementing nonzero counts,
// until a zero count marks the victim; each visited count is read, then checked and, unless zero, written back.
// next beat accepted once the result has moved to the response register.
// reset (synchronous): fill count and hand to zero, cap to 1; memories are not cleared.
module gclock_page_replacement_core
   import gclock_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   gclock_req_if.sink       req_bus,
   gclock_rsp_if.source     rsp_bus,
   input  logic             csr_wr_en,
   input  logic [REF_W-1:0] csr_wr_data
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   // memories
   logic [KEY_W-1:0] key_mem [SLOTS];
   logic [REF_W-1:0] ref_mem [SLOTS];

   state_type         state_ff, state_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [SLOT_W-1:0] hand_ff, hand_in;
   logic [REF_W-1:0]  cap_ff, cap_in;
   logic              res_hit_ff, res_hit_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [KEY_W-1:0]  key_rd_ff;
   logic [REF_W-1:0]  ref_rd_ff;

   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic              key_we;
   logic              ref_we;
   logic [SLOT_W-1:0] wr_addr;
   logic [REF_W-1:0]  ref_wdata;

   logic              req_take;
   logic              match;
   logic              scan_issue;
   logic              scan_miss;
   logic              has_room;
   logic              rsp_free;
   logic [SLOT_W-1:0] hand_next;
   logic [SLOT_W+IDX_W-1:0] res_slot_wide;

   // status terms
   assign req_take   = req_bus.valid && (state_ff == ST_IDLE);
   assign match      = cmp_vld_ff && (key_rd_ff == key_ff);
   assign scan_issue = (state_ff == ST_SCAN) && (rd_ptr_ff < used_ff) && !match;
   assign scan_miss  = (rd_ptr_ff == used_ff) && !match;
   assign has_room   = used_ff < SLOTS_CNT;
   assign rsp_free   = !rsp_vld_ff || rsp_bus.ready;
   assign hand_next  = (hand_ff == LAST_SLOT) ? '0 : hand_ff + SLOT_W'(1);
   assign res_slot_wide = {{IDX_W{1'b0}}, res_slot_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (match) state_in = ST_DONE;
            else if (scan_miss) state_in = has_room ? ST_DONE : ST_SWEEP_RD;
         end
         ST_SWEEP_RD: state_in = ST_SWEEP_CHK;
         ST_SWEEP_CHK: begin
            if (ref_rd_ff == '0) state_in = ST_DONE;
            else state_in = ST_SWEEP_RD;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory port controls
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = rd_ptr_ff[SLOT_W-1:0];
      key_we    = 1'b0;
      ref_we    = 1'b0;
      wr_addr   = cmp_idx_ff;
      ref_wdata = '0;
      case (state_ff)
         ST_SCAN: begin
            rd_en = scan_issue;
            if (match) begin
               ref_we    = ref_rd_ff < cap_ff;
               ref_wdata = ref_rd_ff + REF_W'(1);
            end else if (scan_miss && has_room) begin
               key_we  = 1'b1;
               ref_we  = 1'b1;
               wr_addr = used_ff[SLOT_W-1:0];
            end
         end
         ST_SWEEP_RD: begin
            rd_en   = 1'b1;
            rd_addr = hand_ff;
         end
         ST_SWEEP_CHK: begin
            wr_addr = hand_ff;
            if (ref_rd_ff != '0) begin
               ref_we    = 1'b1;
               ref_wdata = ref_rd_ff - REF_W'(1);
            end else begin
               key_we = 1'b1;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      key_in      = req_take ? req_bus.page_key : key_ff;
      rd_ptr_in   = rd_ptr_ff;
      cmp_vld_in  = scan_issue;
      cmp_idx_in  = scan_issue ? rd_ptr_ff[SLOT_W-1:0] : cmp_idx_ff;
      used_in     = used_ff;
      hand_in     = hand_ff;
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;
      res_hit_in  = res_hit_ff;
      res_slot_in = res_slot_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_bus.ready;
      rsp_hit_in  = rsp_hit_ff;
      rsp_slot_in = rsp_slot_ff;
      if (req_take) rd_ptr_in = '0;
      if (scan_issue) rd_ptr_in = rd_ptr_ff + CNT_W'(1);
      if (state_ff == ST_SCAN) begin
         if (match) begin
            res_hit_in  = 1'b1;
            res_slot_in = cmp_idx_ff;
         end else if (scan_miss && has_room) begin
            res_hit_in  = 1'b0;
            res_slot_in = used_ff[SLOT_W-1:0];
            used_in     = used_ff + CNT_W'(1);
         end
      end
      if (state_ff == ST_SWEEP_CHK) begin
         hand_in = hand_next;
         if (ref_rd_ff == '0) begin
            res_hit_in  = 1'b0;
            res_slot_in = hand_ff;
         end
      end
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_vld_in  = 1'b1;
         rsp_hit_in  = res_hit_ff;
         rsp_slot_in = res_slot_wide[IDX_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_ptr_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         used_ff    <= '0;
         hand_ff    <= '0;
         cap_ff     <= CAP_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_ptr_ff  <= rd_ptr_in;
         cmp_vld_ff <= cmp_vld_in;
         used_ff    <= used_in;
         hand_ff    <= hand_in;
         cap_ff     <= cap_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      cmp_idx_ff  <= cmp_idx_in;
      res_hit_ff  <= res_hit_in;
      res_slot_ff <= res_slot_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   // key memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (key_we) key_mem[wr_addr] <= key_ff;
      if (rd_en) key_rd_ff <= key_mem[rd_addr];
   end

   // reference count memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[wr_addr] <= ref_wdata;
      if (rd_en) ref_rd_ff <= ref_mem[rd_addr];
   end

   // channel outputs
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.hit        = rsp_hit_ff;
   assign rsp_bus.slot_index = rsp_slot_ff;

endmodule

>>> design/gclock_chk.sv
// port-level checker for the gclock page replacement core, with its bind
// depends on gclock_pkg and gclock_page_replacement_core_macros.svh
`include "gclock_page_replacement_core_macros.svh"

module gclock_chk
   import gclock_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_hit,
   input logic [IDX_W-1:0] rsp_slot_index
);

   // one item in flight: accepting a beat makes the block busy
   `GC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled response beat holds its payload
   `GC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_slot_index))

   // a fresh response coincides with the block going idle
   `GC_ASSERT_IMPL(a_rsp_rise_idle, clock, reset, $rose(rsp_valid), req_ready)

   // reported slot lies inside the slot array
   `GC_ASSERT_IMPL(a_slot_range, clock, reset, rsp_valid, (SLOTS >= 64) || (int'(rsp_slot_index) < SLOTS))

endmodule

bind gclock_page_replacement_core gclock_chk #(
   .SLOTS (SLOTS)
) u_gclock_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hit        (rsp_bus.hit),
   .rsp_slot_index (rsp_bus.slot_index)
);

>>> sim/testbench.sv
// testbench for gclock_page_replacement_core: directed and random page fetches,
// checked against a slot and reference-count predictor kept inside the bench
// depends on gclock_pkg, gclock_req_if and gclock_rsp_if from the design
module testbench;
   import gclock_pkg::*;

   localparam int NSLOTS       = SLOTS_DEF;
   localparam int DRAIN_CYCLES = 400;
   localparam longint unsigned RUN_LIMIT = 64'd10_000_000;

   localparam logic [KEY_W-1:0] KEY_ZERO     = 64'h0000_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [KEY_W-1:0] KEY_ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [KEY_W-1:0] KEY_ALT_5    = 64'h5555_5555_5555_5555;
   localparam logic [KEY_W-1:0] KEY_TOP_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_LOW_BIT  = 64'h0000_0000_0000_0001;

   localparam logic [REF_W-1:0] CAP_NONE = 8'd0;
   localparam logic [REF_W-1:0] CAP_ONE  = 8'd1;
   localparam logic [REF_W-1:0] CAP_FULL = 8'd255;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] slot;
   } slot_answer_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [REF_W-1:0] csr_wr_data;

   gclock_req_if req_bus ();
   gclock_rsp_if rsp_bus ();

   gclock_page_replacement_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: resident keys, reference counts, fill level, hand, cap
   logic [KEY_W-1:0] slot_key [NSLOTS];
   logic [REF_W-1:0] slot_ref [NSLOTS];
   int unsigned      used_slots = 0;
   int unsigned      hand_pos   = 0;
   logic [REF_W-1:0] ref_cap    = CAP_RESET;

   slot_answer_type pending_answers[$];
   int              mismatch_count = 0;

   // sender and receiver pacing
   bit offering     = 1'b0;
   bit steady_send  = 1'b0;
   int burst_left   = 0;
   int hold_request = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("gclock_page_replacement_core test failed");
      $finish;
   end

   // work out which slot a key lands in, updating the predicted state
   function automatic void predict_slot(input logic [KEY_W-1:0] key,
                                        output logic hit, output logic [IDX_W-1:0] slot);
      int found = -1;
      for (int i = 0; i < used_slots; i++) begin
         if (found < 0 && slot_key[i] == key) found = i;
      end
      if (found >= 0) begin
         if (slot_ref[found] < ref_cap) slot_ref[found] = slot_ref[found] + 1'b1;
         hit  = 1'b1;
         slot = found[IDX_W-1:0];
      end else if (used_slots < NSLOTS) begin
         slot_key[used_slots] = key;
         slot_ref[used_slots] = '0;
         hit  = 1'b0;
         slot = used_slots[IDX_W-1:0];
         used_slots++;
      end else begin
         // sweep: decrement nonzero counts until a zero count is found
         while (slot_ref[hand_pos] != 0) begin
            slot_ref[hand_pos] = slot_ref[hand_pos] - 1'b1;
            hand_pos = (hand_pos == NSLOTS - 1) ? 0 : hand_pos + 1;
         end
         slot_key[hand_pos] = key;
         hit  = 1'b0;
         slot = hand_pos[IDX_W-1:0];
         hand_pos = (hand_pos == NSLOTS - 1) ? 0 : hand_pos + 1;
      end
   endfunction

   // random key: fresh, resident, or resident with one bit flipped
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] key;
      int roll;
      int flip;
      roll = $urandom_range(0, 99);
      if (used_slots == 0 || roll < ((used_slots < NSLOTS) ? 55 : 30)) begin
         key = {$urandom, $urandom};
      end else begin
         key = slot_key[$urandom_range(0, used_slots - 1)];
         if (roll >= 90) begin
            flip = $urandom_range(0, KEY_W - 1);
            key[flip] = ~key[flip];
         end
      end
      return key;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      $display("mismatch at %0t: %s expected %0d got %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   // offer one request beat, with bursts and gaps unless sending steadily
   task automatic send_key(input logic [KEY_W-1:0] key);
      slot_answer_type answer;
      int gap;
      if (!steady_send && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         if (offering) req_bus.valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid    <= 1'b1;
      req_bus.page_key <= key;
      offering = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_slot(key, answer.hit, answer.slot);
      pending_answers.push_back(answer);
   endtask

   task automatic stop_sending();
      if (offering) req_bus.valid <= 1'b0;
      offering = 1'b0;
   endtask

   task automatic wait_idle();
      stop_sending();
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // cap register write, only with nothing in flight
   task automatic write_cap(input logic [REF_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ref_cap = value;
   endtask

   // key extremes under the reset cap: fills, saturating hits, full-width compare
   task automatic test_key_extremes();
      send_key(KEY_ZERO);
      send_key(KEY_ONES);
      send_key(KEY_ALT_A);
      send_key(KEY_ALT_5);
      send_key(KEY_TOP_BIT);
      send_key(KEY_LOW_BIT);
      repeat (3) send_key(KEY_ONES);
      send_key(KEY_ZERO);
      send_key(KEY_TOP_BIT);
      stop_sending();
   endtask

   // cap of zero holds counts; full cap lets them climb
   task automatic test_cap_limits();
      write_cap(CAP_NONE);
      repeat (3) send_key(KEY_ALT_A);
      write_cap(CAP_FULL);
      repeat (5) send_key(KEY_ALT_5);
      stop_sending();
   endtask

   task automatic test_random_traffic(input logic [REF_W-1:0] cap, input int beats);
      write_cap(cap);
      for (int n = 0; n < beats; n++) send_key(pick_key());
      stop_sending();
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      hold_request = 300;
      steady_send  = 1'b1;
      for (int n = 0; n < 24; n++) send_key(pick_key());
      steady_send = 1'b0;
      stop_sending();
   endtask

   // response ready: random stall patterns plus requested hold-offs
   initial begin
      int hold_left    = 0;
      int pattern_left = 0;
      int stall_mode   = 0;
      int tick         = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (pattern_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready <= ((tick % 7) >= 3);
            endcase
         end
      end
   end

   // compare each response beat with the oldest predicted answer
   always @(posedge clock) begin : check_beat
      slot_answer_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected response, pending count", 0, 1);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.hit !== want.hit)
               report_mismatch("hit", longint'(want.hit), longint'(rsp_bus.hit));
            if (rsp_bus.slot_index !== want.slot)
               report_mismatch("slot_index", longint'(want.slot),
                               longint'(rsp_bus.slot_index));
         end
      end
   end

   // reset, tests in turn, drain, verdict
   initial begin
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.page_key <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_key_extremes();
      test_cap_limits();
      test_random_traffic(CAP_ONE, 100);
      test_random_traffic(CAP_NONE, 100);
      test_backpressure();
      test_random_traffic(CAP_FULL, 80);
      test_random_traffic(8'($urandom_range(2, 254)), 100);
      test_random_traffic(8'd3, 60);
      test_random_traffic(CAP_ONE, 40);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("gclock_page_replacement_core test passed");
      else
         $display("gclock_page_replacement_core test failed");
      $finish;
   end

endmodule
